@@ rtl/bcdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bcdq_pkg
// Shared types and constants for the bounded circular deque.
// ----------------------------------------------------------------------------
package bcdq_pkg;

	// Store depth default and fixed field widths
	localparam int DEPTH_DEF = 1024;
	localparam int DATA_W    = 32;
	localparam int CAP_W     = 11;
	localparam int MODE_W    = 3;

	// Capacity register value after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	// Front and rear read back as all ones on an empty deque
	localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

	// Operation codes
	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_BACK  = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_BACK   = 3'd3,
		MODE_QUERY      = 3'd4
	} mode_t;

endpackage

@@ rtl/bcdq_ram.sv @@
// ----------------------------------------------------------------------------
// bcdq_ram
// Ring store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bcdq_ram #(
	parameter int DEPTH = bcdq_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [AW-1:0]                     waddr,
	input  logic signed [bcdq_pkg::DATA_W-1:0] wdata,
	input  logic                              re,
	input  logic [AW-1:0]                     raddr,
	output logic signed [bcdq_pkg::DATA_W-1:0] rdata
);

	logic signed [bcdq_pkg::DATA_W-1:0] mem [DEPTH];
	logic signed [bcdq_pkg::DATA_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/bounded_circular_deque.sv @@
// Response path: an accepted transaction moves through stage 1 and then into the
//   response registers. Throughput: one transaction per cycle while req_stall is
//   low; a pop's RAM read, if any, feeds the following op and the cached front/rear words.
// Reset: head and occupancy clear to zero, capacity loads 1024, no transaction
//   is held; the ring store is not cleared and no clearing pass is run.
// ----------------------------------------------------------------------------
// bounded_circular_deque
// Bounded double-ended queue of signed words in a ring store, with cached
// front and rear values and at most one RAM read per pop.
// ----------------------------------------------------------------------------
module bounded_circular_deque #(
	parameter int DEPTH = bcdq_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration
	input  logic                               cfg_we,
	input  logic [bcdq_pkg::CAP_W-1:0]         cfg_wdata,
	// Request channel
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [bcdq_pkg::MODE_W-1:0]        mode,
	input  logic signed [bcdq_pkg::DATA_W-1:0] value,
	// Response channel
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic                               ok,
	output logic                               is_empty,
	output logic                               is_full,
	output logic signed [bcdq_pkg::DATA_W-1:0] front_value,
	output logic signed [bcdq_pkg::DATA_W-1:0] rear_value
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int XW = (CW > bcdq_pkg::CAP_W) ? CW : bcdq_pkg::CAP_W;

	// Ring pointer addition, both operands below DEPTH
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(off);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	// State
	logic [bcdq_pkg::CAP_W-1:0]         cap_q;
	logic [AW-1:0]                      head_q;
	logic [CW-1:0]                      occ_q;
	logic signed [bcdq_pkg::DATA_W-1:0] front_q, rear_q;
	logic                               pend_f_q, pend_r_q;

	// Stage 1 and response registers
	logic                               valid_s1, ok_s1, empty_s1, full_s1;
	logic                               rsp_valid_q, ok_q, empty_q, full_q;
	logic signed [bcdq_pkg::DATA_W-1:0] front_out_q, rear_out_q;

	// Combinational
	logic                               accept, s1_move;
	logic [XW-1:0]                      cap_x;
	logic [CW-1:0]                      cap_eff;
	logic                               can_push, can_pop;
	logic [AW-1:0]                      head_dec;
	logic signed [bcdq_pkg::DATA_W-1:0] rd_data, front_eff, rear_eff;
	logic                               ok_c, pend_f_n, pend_r_n;
	logic [AW-1:0]                      head_n;
	logic [CW-1:0]                      occ_n;
	logic signed [bcdq_pkg::DATA_W-1:0] front_n, rear_n;
	logic                               mem_we, mem_re;
	logic [AW-1:0]                      waddr, raddr;

	// Handshakes
	assign s1_move   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !s1_move;
	assign accept    = req_valid && !req_stall;

	// Capacity saturated to the store depth
	assign cap_x    = XW'(cap_q);
	assign cap_eff  = (cap_x > XW'(DEPTH)) ? CW'(DEPTH) : cap_x[CW-1:0];
	assign can_push = occ_q < cap_eff;
	assign can_pop  = occ_q != '0;
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;

	// Cached ends, replaced by RAM data after a pop
	assign front_eff = pend_f_q ? rd_data : front_q;
	assign rear_eff  = pend_r_q ? rd_data : rear_q;

	// Operation decode
	always_comb begin
		ok_c     = 1'b0;
		head_n   = head_q;
		occ_n    = occ_q;
		front_n  = front_eff;
		rear_n   = rear_eff;
		mem_we   = 1'b0;
		waddr    = head_q;
		mem_re   = 1'b0;
		raddr    = head_q;
		pend_f_n = 1'b0;
		pend_r_n = 1'b0;
		case (bcdq_pkg::mode_t'(mode))
			bcdq_pkg::MODE_PUSH_FRONT: begin
				if (can_push) begin
					ok_c    = 1'b1;
					head_n  = head_dec;
					occ_n   = occ_q + 1'b1;
					mem_we  = 1'b1;
					waddr   = head_dec;
					front_n = value;
					if (occ_q == '0) begin
						rear_n = value;
					end
				end
			end
			bcdq_pkg::MODE_PUSH_BACK: begin
				if (can_push) begin
					ok_c   = 1'b1;
					occ_n  = occ_q + 1'b1;
					mem_we = 1'b1;
					waddr  = wrap_add(head_q, occ_q);
					rear_n = value;
					if (occ_q == '0) begin
						front_n = value;
					end
				end
			end
			bcdq_pkg::MODE_POP_FRONT: begin
				if (can_pop) begin
					ok_c   = 1'b1;
					head_n = wrap_add(head_q, CW'(1));
					occ_n  = occ_q - 1'b1;
					if (occ_q != CW'(1)) begin
						mem_re   = 1'b1;
						raddr    = wrap_add(head_q, CW'(1));
						pend_f_n = 1'b1;
					end
				end
			end
			bcdq_pkg::MODE_POP_BACK: begin
				if (can_pop) begin
					ok_c  = 1'b1;
					occ_n = occ_q - 1'b1;
					if (occ_q != CW'(1)) begin
						mem_re   = 1'b1;
						raddr    = wrap_add(head_q, occ_q - CW'(2));
						pend_r_n = 1'b1;
					end
				end
			end
			bcdq_pkg::MODE_QUERY: begin
				ok_c = 1'b1;
			end
			default: begin
				ok_c = 1'b0;
			end
		endcase
	end

	// Ring store
	bcdq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (accept && mem_we),
		.waddr (waddr),
		.wdata (value),
		.re    (accept && mem_re),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bcdq_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Pointer, count and pending flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			occ_q    <= '0;
			pend_f_q <= 1'b0;
			pend_r_q <= 1'b0;
		end else begin
			pend_f_q <= accept && pend_f_n;
			pend_r_q <= accept && pend_r_n;
			if (accept) begin
				head_q <= head_n;
				occ_q  <= occ_n;
			end
		end
	end

	// Cached front and rear words
	always_ff @(posedge clk) begin
		front_q <= accept ? front_n : front_eff;
		rear_q  <= accept ? rear_n : rear_eff;
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !s1_move);
		end
	end

	// Stage 1 flags
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1    <= ok_c;
			empty_s1 <= occ_n == '0;
			full_s1  <= occ_n >= cap_eff;
		end
	end

	// Response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_move) begin
			rsp_valid_q <= valid_s1;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			ok_q        <= ok_s1;
			empty_q     <= empty_s1;
			full_q      <= full_s1;
			front_out_q <= empty_s1 ? bcdq_pkg::EMPTY_WORD : front_eff;
			rear_out_q  <= empty_s1 ? bcdq_pkg::EMPTY_WORD : rear_eff;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign ok          = ok_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;
	assign front_value = front_out_q;
	assign rear_value  = rear_out_q;

`ifndef SYNTH
	// Occupancy moves by at most one per transaction
	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (occ_q == $past(occ_q)) || (occ_q == $past(occ_q) + 1'b1) ||
			(occ_q == $past(occ_q) - 1'b1))
		else $error("occupancy jumped by more than one");

	// Pointer and count hold without a transaction
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(occ_q) && $stable(head_q))
		else $error("deque state changed without a transaction");

	// A pending RAM read only follows an accepted pop
	a_pend_src: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_f_q || pend_r_q) |-> $past(accept) && !(pend_f_q && pend_r_q))
		else $error("pending read without a pop");

	// Occupancy never exceeds the store depth
	a_occ_max: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy above store depth");
`endif

endmodule
